/* hdl/ffrp_pkg.sv */
//------------------------------------------------------------------------------
// ffrp_pkg
// Shared types and codes for the first-fit rectangle placer.
//------------------------------------------------------------------------------
package ffrp_pkg;
  localparam int CW = 12;
  localparam int AW = 28;

  localparam logic [2:0] ST_PLACED  = 3'd0;
  localparam logic [2:0] ST_AREA    = 3'd1;
  localparam logic [2:0] ST_NOPOS   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic REG_LENGTH = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request
    logic clear;       // empty table
    logic area_chk;    // register area compare
    logic orient;      // 1 rotated extents
    logic row_init;    // row index back to 0
    logic row_start;   // take y from the row read, x = 0
    logic row_next;    // advance row index
    logic rect_start;  // begin sweep over rects at current x
    logic rect_step;   // compare one rect
    logic x_advance;   // x = next
    logic row_found;   // record row result
    logic commit;      // store rect
  } ffrp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic area_over;
    logic full;
    logic square;
    logic orient_ok;   // panel fits inside layer
    logic row_skip;    // row unusable or not better
    logic row_last;    // last candidate row
    logic x_over;      // x + ex > layer length
    logic rect_done;   // sweep over rects finished
    logic x_fixed;     // next == x
    logic found;
  } ffrp_stat_t;
endpackage

/* hdl/ffrp_if.sv */
//------------------------------------------------------------------------------
// ffrp_if
// Valid/ready channel with a generic payload.
//------------------------------------------------------------------------------
interface ffrp_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ffrp_ctrl.sv */
//------------------------------------------------------------------------------
// ffrp_ctrl
// Sequencer for the area check, row scan and commit of one request.
//------------------------------------------------------------------------------
module ffrp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          res_status,
  output logic                res_rot,
  output ffrp_pkg::ffrp_cmd_t cmd,
  input  ffrp_pkg::ffrp_stat_t stat
);
  import ffrp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_AREA = 4'd1, S_DEC = 4'd2,
                         S_ORI = 4'd3, S_ROW = 4'd4, S_CHK = 4'd5,
                         S_RECT = 4'd6, S_XEND = 4'd7, S_NEXTROW = 4'd8,
                         S_OUT = 4'd9, S_ROWY = 4'd10;

  logic [3:0] state, state_next;
  logic       rot, rot_next;
  logic [2:0] st_next;
  logic       ov_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    rot_next   = rot;
    st_next    = res_status;
    ov_next    = out_valid;
    cmd        = '0;
    cmd.orient = rot;
    if (out_valid && out_ready) ov_next = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load   = 1'b1;
        state_next = S_AREA;
      end
      S_AREA: begin
        cmd.area_chk = 1'b1;
        state_next   = S_DEC;
      end
      S_DEC: begin
        rot_next = 1'b0;
        priority if (stat.is_clear) begin
          cmd.clear = 1'b1; st_next = ST_CLEARED; state_next = S_OUT;
        end else if (stat.area_over) begin
          st_next = ST_AREA; state_next = S_OUT;
        end else if (stat.full) begin
          st_next = ST_FULL; state_next = S_OUT;
        end else begin
          state_next = S_ORI;
        end
      end
      S_ORI: begin
        cmd.row_init = 1'b1;
        if (stat.orient_ok) begin
          state_next = S_ROW;
        end else begin
          state_next = S_XEND;
        end
      end
      // table read of the row's source rect is in flight
      S_ROW: state_next = S_ROWY;
      S_ROWY: begin
        cmd.row_start = 1'b1; state_next = S_CHK;
      end
      S_CHK: begin
        priority if (stat.row_skip || stat.x_over) begin
          state_next = S_NEXTROW;
        end else begin
          cmd.rect_start = 1'b1; state_next = S_RECT;
        end
      end
      S_RECT: begin
        if (stat.rect_done) begin
          if (stat.x_fixed) begin
            cmd.row_found = 1'b1; state_next = S_NEXTROW;
          end else begin
            cmd.x_advance = 1'b1; state_next = S_CHK;
          end
        end else begin
          cmd.rect_step = 1'b1;
        end
      end
      S_NEXTROW: begin
        if (stat.row_last) begin
          state_next = S_XEND;
        end else begin
          cmd.row_next = 1'b1; state_next = S_ROW;
        end
      end
      S_XEND: begin
        priority if (stat.found) begin
          cmd.commit = 1'b1; st_next = ST_PLACED; state_next = S_OUT;
        end else if (!rot && !stat.square) begin
          rot_next = 1'b1; state_next = S_ORI;
        end else begin
          rot_next = 1'b0; st_next = ST_NOPOS; state_next = S_OUT;
        end
      end
      S_OUT: begin
        ov_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rot <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= ov_next;
      rot <= rot_next;
    end
    res_status <= st_next;
  end
  assign res_rot = rot;
endmodule

/* hdl/ffrp_dp.sv */
//------------------------------------------------------------------------------
// ffrp_dp
// Rectangle table, area accumulator and scan registers.
//------------------------------------------------------------------------------
module ffrp_dp #(
  parameter int MAX_RECTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [11:0]          cfg_data,
  input  logic                 in_cmd,
  input  logic [11:0]          in_pl,
  input  logic [11:0]          in_pw,
  input  ffrp_pkg::ffrp_cmd_t  cmd,
  output ffrp_pkg::ffrp_stat_t stat,
  output logic [11:0]          pos_x,
  output logic [11:0]          pos_y
);
  import ffrp_pkg::*;

  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int NW = $clog2(MAX_RECTS + 1);
  localparam int SW = CW + 2;  // edge plus extent, plus one more extent

  logic [4*CW-1:0] mem [MAX_RECTS];
  logic [CW-1:0] llen, lwid;
  logic [NW-1:0] count;
  logic [AW-1:0] used;
  logic          rq_clear;
  logic [CW-1:0] pl, pw;
  logic [AW-1:0] area;
  logic          over;
  logic [CW-1:0] ex, ey;
  logic [NW-1:0] row_i;
  logic [NW-1:0] rect_i;
  logic [SW-1:0] y, x, nxt;
  logic          found;
  logic [CW-1:0] best_x, best_y;
  logic [CW-1:0] fx_ex, fx_ey;
  logic [4*CW-1:0] rd;
  logic [IW-1:0]   raddr;
  logic [SW-1:0]   row_y;
  logic [SW-1:0]   rx_end, ry_end;
  logic            hit;

  assign ex = cmd.orient ? pw : pl;
  assign ey = cmd.orient ? pl : pw;

  always_ff @(posedge clk) begin
    if (rst) begin
      llen <= 12'd2048;
      lwid <= 12'd1024;
    end else if (cfg_we) begin
      if (cfg_idx == REG_LENGTH) llen <= cfg_data;
      else lwid <= cfg_data;
    end
  end

  // table entry: {x, y, ex, ey}; read port serves the rect sweep, else the row source
  always_comb begin
    priority if (cmd.rect_start) raddr = '0;
    else if (cmd.rect_step) raddr = rect_i[IW-1:0] + IW'(1);
    else if (row_i == '0) raddr = '0;
    else raddr = IW'(row_i - NW'(1));
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (cmd.commit)
      mem[count[IW-1:0]] <= {best_x, best_y, fx_ex, fx_ey};
  end

  // row candidates: 0, then top edge of each stored rect
  assign row_y = (row_i == '0) ? '0 : SW'(rd[3*CW-1:2*CW]) + SW'(rd[CW-1:0]);

  assign rx_end = SW'(rd[4*CW-1:3*CW]) + SW'(rd[2*CW-1:CW]);
  assign ry_end = SW'(rd[3*CW-1:2*CW]) + SW'(rd[CW-1:0]);
  assign hit = (x < rx_end) && (x + SW'(ex) > SW'(rd[4*CW-1:3*CW])) &&
               (y < ry_end) && (y + SW'(ey) > SW'(rd[3*CW-1:2*CW]));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      used  <= '0;
    end else if (cmd.commit) begin
      count <= count + NW'(1);
      used  <= used + area;
    end
    if (cmd.load) begin
      rq_clear <= in_cmd;
      pl <= in_pl;
      pw <= in_pw;
      found <= 1'b0;
    end
    if (cmd.load) area <= AW'(in_pl) * AW'(in_pw);
    if (cmd.area_chk)
      over <= ({1'b0, used} + {1'b0, area}) > ((AW+1)'(llen) * (AW+1)'(lwid));
    if (cmd.row_start) begin
      y <= row_y;
      x <= '0;
    end
    if (cmd.rect_start) begin
      rect_i <= '0;
      nxt <= x;
    end
    if (cmd.rect_step) begin
      rect_i <= rect_i + NW'(1);
      if (hit && rx_end > nxt) nxt <= rx_end;
    end
    if (cmd.x_advance) x <= nxt;
    if (cmd.row_found) begin
      found  <= 1'b1;
      best_x <= x[CW-1:0];
      best_y <= y[CW-1:0];
      fx_ex  <= ex;
      fx_ey  <= ey;
    end
  end

  // row index sequencing
  always_ff @(posedge clk) begin
    if (cmd.row_init) row_i <= '0;
    else if (cmd.row_next) row_i <= row_i + NW'(1);
  end

  assign stat.is_clear  = rq_clear;
  assign stat.area_over = over;
  assign stat.full      = (count == NW'(MAX_RECTS));
  assign stat.square    = (pl == pw);
  assign stat.orient_ok = (ex <= llen) && (ey <= lwid);
  assign stat.row_skip  = (y + SW'(ey) > SW'(lwid)) || (found && y >= SW'(best_y));
  assign stat.row_last  = (row_i >= count);
  assign stat.x_over    = x + SW'(ex) > SW'(llen);
  assign stat.rect_done = (rect_i >= count);
  assign stat.x_fixed   = (nxt == x);
  assign stat.found     = found;

  assign pos_x = found ? best_x : '0;
  assign pos_y = found ? best_y : '0;
endmodule

/* hdl/first_fit_rectangle_placer_top.sv */
//------------------------------------------------------------------------------
// first_fit_rectangle_placer_top
// Bottom-left first-fit placer for one layer of rectangles.
//------------------------------------------------------------------------------
// One request is handled at a time; the next request beat is taken the cycle
// after the result beat leaves. A clear, or a request refused for area or a
// full table, offers its result straight after the area check and the
// decision. A placement passes the same area check, then per orientation
// tried (rotated only if upright fails and the panel is not square) a setup
// state and up to count+1 candidate rows: each row reads its source rect and
// is checked, each x position tested sweeps every stored rectangle through the
// table read port, and a row that ends at its check moves straight on. A
// final decision and the result state end the request. The time is data
// dependent and grows roughly with the cube of the stored count.
module first_fit_rectangle_placer_top #(
  parameter int MAX_RECTS = 16
) (
  input logic clk,
  input logic rst,
  ffrp_if.sink   cfg,
  ffrp_if.sink   in_ch,
  ffrp_if.source out_ch
);
  import ffrp_pkg::*;

  ffrp_cmd_t  cmd;
  ffrp_stat_t stat;
  logic [2:0] st;
  logic       rot;
  logic [11:0] px, py;

  assign cfg.ready = 1'b1;

  ffrp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .res_status(st), .res_rot(rot), .cmd, .stat
  );

  ffrp_dp #(.MAX_RECTS(MAX_RECTS)) u_dp (
    .clk, .rst,
    .cfg_we  (cfg.valid), .cfg_idx(cfg.data[12]), .cfg_data(cfg.data[11:0]),
    .in_cmd  (in_ch.data[24]), .in_pl(in_ch.data[23:12]), .in_pw(in_ch.data[11:0]),
    .cmd, .stat, .pos_x(px), .pos_y(py)
  );

  assign out_ch.data = {st, px, py, (st == ST_PLACED) ? rot : 1'b0};
endmodule
